>>> src/ets_pkg.sv
// Shared widths, constants, types and helper functions of the epoch-to-civil-time pipeline.
package ets_pkg;

    localparam int SECONDS_WIDTH = 41;
    localparam int ZONE_W        = 11;
    localparam int ZSEC_W        = 17;
    localparam int SEC_PER_MIN   = 60;

    localparam int YEAR_W  = 17;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int WDAY_W  = 3;

    // Seconds counted from 0000-03-01, offset by half the range so the value is unsigned.
    localparam int T_W = ((SECONDS_WIDTH > 37) ? SECONDS_WIDTH : 37) + 1;

    // One 400-year era is 146097 days of 86400 s = 2^7 * 98615475 s.
    localparam int LOW_W     = 7;
    localparam int REM_W     = 27;
    localparam int INIT_W    = 26;
    localparam int ERA_SEC_W = 34;
    localparam int STEP_BITS = 4;
    localparam int NQ        = T_W - LOW_W - INIT_W;
    localparam int N_STG     = (NQ + STEP_BITS - 1) / STEP_BITS;
    localparam int QW        = N_STG * STEP_BITS;
    localparam int DP_W      = INIT_W + QW;

    localparam logic [REM_W:0]       ERA_DIV   = 28'd98615475;
    localparam logic [ERA_SEC_W-1:0] ERA_SEC   = 34'd12622780800;
    localparam logic [T_W-1:0]       ERA_SEC_T = T_W'(ERA_SEC);
    localparam logic [T_W-1:0]       BIAS      = {1'b1, {(T_W - 1){1'b0}}};
    localparam logic [T_W-1:0]       BIAS_Q    = BIAS / ERA_SEC_T;
    localparam logic [ERA_SEC_W-1:0] BIAS_R    = ERA_SEC_W'(BIAS % ERA_SEC_T);
    localparam logic [T_W-1:0]       EPOCH_SEC = T_W'(64'd62162035200);
    localparam logic [T_W-1:0]       ZONE_BASE = BIAS + EPOCH_SEC;

    // Day of era from the seconds remainder: x / 675 by reciprocal.
    localparam int DOE_W = 18;
    localparam int DOE_K = 37;
    localparam logic [27:0] DOE_M  = 28'd203613265;
    localparam int          DAY_DIV = 675;

    localparam int REST_W = 17;
    localparam int M60_W  = 11;
    localparam int YOE_W  = 9;
    localparam int DOY_W  = 9;
    localparam int MP_W   = 4;

    localparam logic [18:0] M60   = 19'd279621;
    localparam int          K60   = 24;
    localparam logic [18:0] M1460 = 19'd367720;
    localparam int          K1460 = 29;
    localparam logic [18:0] M7    = 19'd299594;
    localparam int          K7    = 21;
    localparam logic [18:0] M365  = 19'd367720;
    localparam int          K365  = 27;
    localparam logic [10:0] M153  = 11'd1714;
    localparam int          K153  = 18;

    localparam int DAYS_CENT    = 36524;
    localparam int DAYS_ERA_END = 146096;
    localparam int MP_JAN       = 10;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QW-1:0]    acc;
    } ets_div_t;

    // Four restoring long-division steps: dividend bits leave acc at the top,
    // quotient bits enter at the bottom.
    function automatic ets_div_t ets_div_stage(ets_div_t x);
        ets_div_t       y;
        logic [REM_W:0] trial;
        y = x;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            trial = {y.rem, y.acc[QW-1]};
            y.acc = {y.acc[QW-2:0], 1'b0};
            if (trial >= ERA_DIV)
            begin
                trial    = trial - ERA_DIV;
                y.acc[0] = 1'b1;
            end
            y.rem = trial[REM_W-1:0];
        end
        return y;
    endfunction

    // Days before the first of a month, months counted from March.
    function automatic logic [DOY_W-1:0] ets_month_start(logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/ets_era_div.sv
// Pipelined long division of shifted seconds by the length of a 400-year era.
module ets_era_div import ets_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [DP_W-1:0]  in_dvd,
    input  logic [LOW_W-1:0] in_low,
    output logic             out_valid,
    output ets_div_t         out_q,
    output logic [LOW_W-1:0] out_low
);

    logic [N_STG-1:0] stg_v_reg;
    logic [N_STG-1:0] stg_v_next;
    ets_div_t         stg_src  [N_STG];
    ets_div_t         stg_next [N_STG];
    ets_div_t         stg_reg  [N_STG];
    logic [LOW_W-1:0] low_reg  [N_STG];

    // The top bits of the dividend are always below the divisor, so they seed the remainder.
    always_comb
    begin
        stg_src[0].rem = REM_W'(in_dvd[DP_W-1 -: INIT_W]);
        stg_src[0].acc = in_dvd[QW-1:0];
        for (int i = 1; i < N_STG; i++)
        begin
            stg_src[i] = stg_reg[i-1];
        end
    end

    always_comb
    begin
        for (int i = 0; i < N_STG; i++)
        begin
            stg_next[i] = ets_div_stage(stg_src[i]);
        end
    end

    assign stg_v_next = {stg_v_reg[N_STG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_v_reg <= '0;
        end
        else
        begin
            stg_v_reg <= stg_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg[0] <= in_low;
        for (int i = 0; i < N_STG; i++)
        begin
            stg_reg[i] <= stg_next[i];
        end
        for (int i = 1; i < N_STG; i++)
        begin
            low_reg[i] <= low_reg[i-1];
        end
    end

    assign out_valid = stg_v_reg[N_STG-1];
    assign out_q     = stg_reg[N_STG-1];
    assign out_low   = low_reg[N_STG-1];

endmodule

>>> src/epoch_seconds_to_civil_time.sv
// Top level: pipelined conversion of signed epoch seconds to local civil date and time.
//
// A beat is taken on every cycle that start is high; busy stays low because the pipeline
// never stalls. Each beat comes out, in order, on the cycle that done is high. It passes
// the input register, the N stages of the era long division (four quotient bits per
// stage, N = ceil((max(SECONDS_WIDTH, 37) - 32) / 4)), the stages P1 to P7 and the
// output registers. The zone offset write applies to every beat taken after the write
// edge; write it only while no beat is in flight.
module epoch_seconds_to_civil_time import ets_pkg::*; (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [SECONDS_WIDTH-1:0] unix_seconds,
    input  logic                            zone_offset_we,
    input  logic signed [ZONE_W-1:0]        zone_offset_minutes,
    output logic                            done,
    output logic signed [YEAR_W-1:0]        year,
    output logic [MONTH_W-1:0]              month,
    output logic [DAY_W-1:0]                day_of_month,
    output logic [HOUR_W-1:0]               hour,
    output logic [MIN_W-1:0]                minute,
    output logic [MIN_W-1:0]                second,
    output logic [WDAY_W-1:0]               weekday
);

    // Zone offset, held premultiplied and with the epoch and range bias folded in.
    logic [T_W-1:0]           zone_bias_reg;
    logic [T_W-1:0]           zone_bias_next;
    logic signed [ZSEC_W-1:0] zone_sec;

    logic             s0_v_reg;
    logic [T_W-1:0]   s0_sum;
    logic [DP_W-1:0]  s0_dvd_reg;
    logic [DP_W-1:0]  s0_dvd_next;
    logic [LOW_W-1:0] s0_low_reg;

    logic             div_v;
    ets_div_t         div_q;
    logic [LOW_W-1:0] div_low;

    logic [7:0] pv_reg;
    logic [7:0] pv_next;

    // P1: era and seconds within the era
    logic [ERA_SEC_W-1:0] p1_ru;
    logic                 p1_borrow;
    logic [ERA_SEC_W-1:0] p1_r_reg, p1_r_next;
    logic [YEAR_W-1:0]    p1_era_reg, p1_era_next;

    // P2: day of era
    logic [54:0]       p2_prod;
    logic [DOE_W-1:0]  p2_doe_reg, p2_doe_next;
    logic [REM_W-1:0]  p2_x_reg;
    logic [LOW_W-1:0]  p2_low_reg;
    logic [YEAR_W-1:0] p2_e400_reg, p2_e400_next;

    // P3
    logic [REM_W-1:0]  p3_doe675;
    logic [36:0]       p3_prod1460;
    logic [36:0]       p3_prod7;
    logic [DOE_W-1:0]  p3_n;
    logic [REST_W-1:0] p3_rest_reg, p3_rest_next;
    logic [6:0]        p3_q1460_reg, p3_q1460_next;
    logic [2:0]        p3_q36524_reg, p3_q36524_next;
    logic              p3_last_reg, p3_last_next;
    logic [DOE_W-1:0]  p3_n_reg;
    logic [14:0]       p3_q7_reg, p3_q7_next;
    logic [DOE_W-1:0]  p3_doe_reg;
    logic [YEAR_W-1:0] p3_e400_reg;

    // P4
    logic [35:0]       p4_prod60;
    logic [DOE_W-1:0]  p4_num_reg, p4_num_next;
    logic [WDAY_W-1:0] p4_wd_reg, p4_wd_next;
    logic [M60_W-1:0]  p4_m60_reg, p4_m60_next;
    logic [REST_W-1:0] p4_rest_reg;
    logic [DOE_W-1:0]  p4_doe_reg;
    logic [YEAR_W-1:0] p4_e400_reg;

    // P5
    logic [36:0]       p5_prod365;
    logic [29:0]       p5_prodh;
    logic [YOE_W-1:0]  p5_yoe_reg, p5_yoe_next;
    logic [MIN_W-1:0]  p5_sec_reg, p5_sec_next;
    logic [HOUR_W-1:0] p5_hour_reg, p5_hour_next;
    logic [M60_W-1:0]  p5_m60_reg;
    logic [DOE_W-1:0]  p5_doe_reg;
    logic [YEAR_W-1:0] p5_e400_reg;
    logic [WDAY_W-1:0] p5_wd_reg;

    // P6
    logic [1:0]        p6_q100;
    logic [DOE_W-1:0]  p6_ystart;
    logic [DOY_W-1:0]  p6_doy_reg, p6_doy_next;
    logic [MIN_W-1:0]  p6_min_reg, p6_min_next;
    logic [YOE_W-1:0]  p6_yoe_reg;
    logic [YEAR_W-1:0] p6_e400_reg;
    logic [MIN_W-1:0]  p6_sec_reg;
    logic [HOUR_W-1:0] p6_hour_reg;
    logic [WDAY_W-1:0] p6_wd_reg;

    // P7
    logic [10:0]       p7_t;
    logic [21:0]       p7_prod;
    logic [MP_W-1:0]   p7_mp_reg, p7_mp_next;
    logic [DOY_W-1:0]  p7_doy_reg;
    logic [YOE_W-1:0]  p7_yoe_reg;
    logic [YEAR_W-1:0] p7_e400_reg;
    logic [MIN_W-1:0]  p7_min_reg;
    logic [MIN_W-1:0]  p7_sec_reg;
    logic [HOUR_W-1:0] p7_hour_reg;
    logic [WDAY_W-1:0] p7_wd_reg;

    // Output registers
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg, day_next;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   minute_reg;
    logic [MIN_W-1:0]   second_reg;
    logic [WDAY_W-1:0]  weekday_reg;

    assign busy = 1'b0;

    always_comb
    begin
        zone_sec       = ZSEC_W'(zone_offset_minutes) * ZSEC_W'(SEC_PER_MIN);
        zone_bias_next = zone_offset_we ? ZONE_BASE + T_W'(zone_sec) : zone_bias_reg;
    end

    // The sum is exact in T_W bits: the bias keeps it inside the unsigned range.
    always_comb
    begin
        s0_sum      = T_W'(unix_seconds) + zone_bias_reg;
        s0_dvd_next = DP_W'(s0_sum[T_W-1:LOW_W]);
    end

    ets_era_div u_era_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s0_v_reg),
        .in_dvd    (s0_dvd_reg),
        .in_low    (s0_low_reg),
        .out_valid (div_v),
        .out_q     (div_q),
        .out_low   (div_low)
    );

    assign pv_next = {pv_reg[6:0], div_v};

    // Undo the range bias; only the low bits of the era matter for a 17-bit year.
    always_comb
    begin
        p1_ru       = {div_q.rem, div_low};
        p1_borrow   = p1_ru < BIAS_R;
        p1_r_next   = p1_ru - BIAS_R + (p1_borrow ? ERA_SEC : ERA_SEC_W'(0));
        p1_era_next = YEAR_W'(div_q.acc) - YEAR_W'(BIAS_Q) - YEAR_W'(p1_borrow);
    end

    always_comb
    begin
        p2_prod      = 55'(p1_r_reg[ERA_SEC_W-1:LOW_W]) * 55'(DOE_M);
        p2_doe_next  = p2_prod[DOE_K +: DOE_W];
        p2_e400_next = (p1_era_reg << 8) + (p1_era_reg << 7) + (p1_era_reg << 4);
    end

    always_comb
    begin
        p3_doe675      = REM_W'(p2_doe_reg) * REM_W'(DAY_DIV);
        p3_rest_next   = {10'(p2_x_reg - p3_doe675), p2_low_reg};
        p3_prod1460    = 37'(p2_doe_reg) * 37'(M1460);
        p3_q1460_next  = p3_prod1460[K1460 +: 7];
        p3_q36524_next = 3'(p2_doe_reg >= DOE_W'(DAYS_CENT))
                       + 3'(p2_doe_reg >= DOE_W'(2 * DAYS_CENT))
                       + 3'(p2_doe_reg >= DOE_W'(3 * DAYS_CENT))
                       + 3'(p2_doe_reg >= DOE_W'(4 * DAYS_CENT));
        p3_last_next   = p2_doe_reg == DOE_W'(DAYS_ERA_END);
        // An era is a whole number of weeks, and day 0 of an era is a Wednesday.
        p3_n           = p2_doe_reg + DOE_W'(3);
        p3_prod7       = 37'(p3_n) * 37'(M7);
        p3_q7_next     = p3_prod7[K7 +: 15];
    end

    always_comb
    begin
        p4_num_next = p3_doe_reg - DOE_W'(p3_q1460_reg) + DOE_W'(p3_q36524_reg)
                    - DOE_W'(p3_last_reg);
        p4_wd_next  = WDAY_W'(p3_n_reg - DOE_W'(DOE_W'(p3_q7_reg) * DOE_W'(7)));
        p4_prod60   = 36'(p3_rest_reg) * 36'(M60);
        p4_m60_next = p4_prod60[K60 +: M60_W];
    end

    always_comb
    begin
        p5_prod365   = 37'(p4_num_reg) * 37'(M365);
        p5_yoe_next  = p5_prod365[K365 +: YOE_W];
        p5_sec_next  = MIN_W'(p4_rest_reg - REST_W'(REST_W'(p4_m60_reg) * REST_W'(SEC_PER_MIN)));
        p5_prodh     = 30'(p4_m60_reg) * 30'(M60);
        p5_hour_next = p5_prodh[K60 +: HOUR_W];
    end

    always_comb
    begin
        p6_q100     = 2'(p5_yoe_reg >= YOE_W'(100)) + 2'(p5_yoe_reg >= YOE_W'(200))
                    + 2'(p5_yoe_reg >= YOE_W'(300));
        p6_ystart   = DOE_W'(p5_yoe_reg) * DOE_W'(365) + DOE_W'(p5_yoe_reg >> 2)
                    - DOE_W'(p6_q100);
        p6_doy_next = DOY_W'(p5_doe_reg - p6_ystart);
        p6_min_next = MIN_W'(p5_m60_reg - M60_W'(M60_W'(p5_hour_reg) * M60_W'(SEC_PER_MIN)));
    end

    always_comb
    begin
        p7_t       = (11'(p6_doy_reg) << 2) + 11'(p6_doy_reg) + 11'd2;
        p7_prod    = 22'(p7_t) * 22'(M153);
        p7_mp_next = p7_prod[K153 +: MP_W];
    end

    // January and February belong to the next civil year.
    always_comb
    begin
        day_next   = DAY_W'(p7_doy_reg - ets_month_start(p7_mp_reg) + DOY_W'(1));
        month_next = (p7_mp_reg < MP_W'(MP_JAN)) ? p7_mp_reg + MP_W'(3) : p7_mp_reg - MP_W'(9);
        year_next  = p7_e400_reg + YEAR_W'(p7_yoe_reg) + YEAR_W'(p7_mp_reg >= MP_W'(MP_JAN));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_bias_reg <= ZONE_BASE;
            s0_v_reg      <= 1'b0;
            pv_reg        <= '0;
        end
        else
        begin
            zone_bias_reg <= zone_bias_next;
            s0_v_reg      <= start & ~busy;
            pv_reg        <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_dvd_reg    <= s0_dvd_next;
        s0_low_reg    <= s0_sum[LOW_W-1:0];

        p1_r_reg      <= p1_r_next;
        p1_era_reg    <= p1_era_next;

        p2_doe_reg    <= p2_doe_next;
        p2_x_reg      <= p1_r_reg[ERA_SEC_W-1:LOW_W];
        p2_low_reg    <= p1_r_reg[LOW_W-1:0];
        p2_e400_reg   <= p2_e400_next;

        p3_rest_reg   <= p3_rest_next;
        p3_q1460_reg  <= p3_q1460_next;
        p3_q36524_reg <= p3_q36524_next;
        p3_last_reg   <= p3_last_next;
        p3_n_reg      <= p3_n;
        p3_q7_reg     <= p3_q7_next;
        p3_doe_reg    <= p2_doe_reg;
        p3_e400_reg   <= p2_e400_reg;

        p4_num_reg    <= p4_num_next;
        p4_wd_reg     <= p4_wd_next;
        p4_m60_reg    <= p4_m60_next;
        p4_rest_reg   <= p3_rest_reg;
        p4_doe_reg    <= p3_doe_reg;
        p4_e400_reg   <= p3_e400_reg;

        p5_yoe_reg    <= p5_yoe_next;
        p5_sec_reg    <= p5_sec_next;
        p5_hour_reg   <= p5_hour_next;
        p5_m60_reg    <= p4_m60_reg;
        p5_doe_reg    <= p4_doe_reg;
        p5_e400_reg   <= p4_e400_reg;
        p5_wd_reg     <= p4_wd_reg;

        p6_doy_reg    <= p6_doy_next;
        p6_min_reg    <= p6_min_next;
        p6_yoe_reg    <= p5_yoe_reg;
        p6_e400_reg   <= p5_e400_reg;
        p6_sec_reg    <= p5_sec_reg;
        p6_hour_reg   <= p5_hour_reg;
        p6_wd_reg     <= p5_wd_reg;

        p7_mp_reg     <= p7_mp_next;
        p7_doy_reg    <= p6_doy_reg;
        p7_yoe_reg    <= p6_yoe_reg;
        p7_e400_reg   <= p6_e400_reg;
        p7_min_reg    <= p6_min_reg;
        p7_sec_reg    <= p6_sec_reg;
        p7_hour_reg   <= p6_hour_reg;
        p7_wd_reg     <= p6_wd_reg;

        year_reg      <= year_next;
        month_reg     <= month_next;
        day_reg       <= day_next;
        hour_reg      <= p7_hour_reg;
        minute_reg    <= p7_min_reg;
        second_reg    <= p7_sec_reg;
        weekday_reg   <= p7_wd_reg;
    end

    assign done         = pv_reg[7];
    assign year         = $signed(year_reg);
    assign month        = month_reg;
    assign day_of_month = day_reg;
    assign hour         = hour_reg;
    assign minute       = minute_reg;
    assign second       = second_reg;
    assign weekday      = weekday_reg;

endmodule
